@@ design/lrast_pkg.sv @@
// shared constants and types for the lazy range add / range sum tree
// no dependencies; used by lrast_node_store and lazy_range_add_sum_tree_unit
package lrast_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = $clog2(MAX_ELEMENTS);
  localparam int SPAN         = 1 << LEVELS;
  localparam int NODE_CNT     = 2 * SPAN;
  localparam int IDX_W        = LEVELS;
  localparam int NODE_W       = LEVELS + 1;
  localparam int LVL_W        = $clog2(LEVELS + 1);
  localparam int LEN_W        = 11;
  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 2;

  localparam logic [LVL_W-1:0]  TREE_LEVELS = LVL_W'(LEVELS);
  localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_ELEMENTS);
  localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(1024);

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUM  = 2'd2;

  // register index (address bit 2 and up)
  localparam logic REG_USED_LENGTH = 1'b0;

  typedef struct packed {
    logic                sum_we;
    logic                pend_we;
    logic [NODE_W-1:0]   addr;
    logic [DATA_W-1:0]   sum;
    logic [DATA_W-1:0]   pend;
  } node_wr_t;

endpackage

@@ design/lrast_node_store.sv @@
// node storage: per-node segment sums and per-node pending adds
// one write port, one read port with registered data; uses lrast_pkg
module lrast_node_store (
  input  logic                          clk,
  input  lrast_pkg::node_wr_t           wr,
  input  logic [lrast_pkg::NODE_W-1:0]  rd_addr,
  output logic [lrast_pkg::DATA_W-1:0]  rd_sum,
  output logic [lrast_pkg::DATA_W-1:0]  rd_pend
);

  logic [lrast_pkg::DATA_W-1:0] sum_mem  [0:lrast_pkg::NODE_CNT-1];
  logic [lrast_pkg::DATA_W-1:0] pend_mem [0:lrast_pkg::NODE_CNT-1];

  always_ff @(posedge clk) begin
    if (wr.sum_we) begin
      sum_mem[wr.addr] <= wr.sum;
    end
    rd_sum <= sum_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.pend_we) begin
      pend_mem[wr.addr] <= wr.pend;
    end
    rd_pend <= pend_mem[rd_addr];
  end

endmodule

@@ design/lazy_range_add_sum_tree_unit.sv @@
// top level: segment tree with deferred range add and range sum over 1024 elements
// depends on lrast_pkg and lrast_node_store
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid/in_tready    tuser: func; tdata: index_low, index_high, value
//  out_      master     out_tvalid/out_tready  tdata: range_total
//  cfg_      apb slave  psel/penable/pready    used_length at byte address 0
//
// one item at a time; each tree node visit is a read state plus an evaluate state,
// a partially covered node on a range add also passes the multiply and write back states,
// and moving back up the tree passes the ascend state once per level; a load walks down
// to its leaf, then reads and writes back each ancestor sum; ignored items and empty
// adds leave the unit idle, an empty sum goes straight to the finish state
// after reset a clearing pass zeroes all 2048 node entries, no item accepted
// a finished sum waits in the output register; a second sum stalls only at its end
module lazy_range_add_sum_tree_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [9:0] index_low, [19:10] index_high, [51:20] value, zero pad
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] range_total
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW = lrast_pkg::NODE_W;
  localparam int DW = lrast_pkg::DATA_W;
  localparam int IW = lrast_pkg::IDX_W;
  localparam int LW = lrast_pkg::LVL_W;
  localparam int CW = lrast_pkg::LEN_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_EVAL, ST_MUL, ST_PWR, ST_ASC, ST_LUR, ST_LUW, ST_FIN
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               used_len_r;
  logic [NW-1:0]               clr_cnt_r;
  logic [NW-1:0]               node_r;
  logic [LW-1:0]               lvl_r;
  logic [lrast_pkg::FUNC_W-1:0] func_r;
  logic [IW-1:0]               ql_r;
  logic [IW-1:0]               qh_r;
  logic [DW-1:0]               value_r;
  logic [DW-1:0]               acc_r [0:lrast_pkg::LEVELS];
  logic [DW-1:0]               total_r;
  logic [DW-1:0]               delta_r;
  logic [DW-1:0]               keep_r;
  logic [DW-1:0]               prod_r;
  logic [CW-1:0]               cnt_r;
  logic                        out_valid_r;
  logic [DW-1:0]               out_data_r;

  lrast_pkg::node_wr_t         wr;
  logic [DW-1:0]               rd_sum;
  logic [DW-1:0]               rd_pend;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == lrast_pkg::REG_USED_LENGTH) ?
                      {{(32-CW){1'b0}}, used_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_len_r <= lrast_pkg::LEN_RESET;
    end else if (cfg_wr && cfg_paddr[2] == lrast_pkg::REG_USED_LENGTH) begin
      used_len_r <= cfg_pwdata[CW-1:0];
    end
  end

  // ---------------- request decode at accept ----------------
  logic [IW-1:0]  in_ql;
  logic [IW-1:0]  in_qh;
  logic [DW-1:0]  in_value;
  logic [CW-1:0]  len;
  logic [IW-1:0]  qh_clip;
  logic           empty;
  logic           in_acc;

  assign in_ql    = in_tdata[9:0];
  assign in_qh    = in_tdata[19:10];
  assign in_value = in_tdata[51:20];
  assign len      = (used_len_r > lrast_pkg::LEN_MAX) ? lrast_pkg::LEN_MAX : used_len_r;

  always_comb begin
    qh_clip = in_qh;
    if (len != '0 && {1'b0, in_qh} > len - CW'(1)) begin
      qh_clip = IW'(len - CW'(1));
    end
  end
  assign empty     = (len == '0) || (in_ql > qh_clip);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- current node geometry ----------------
  logic [LW-1:0]  shamt;
  logic [NW-1:0]  size;
  logic [NW-1:0]  off;
  logic [IW-1:0]  lo;
  logic [IW-1:0]  hi;
  logic           disjoint;
  logic           covered;
  logic [IW-1:0]  ov_lo;
  logic [IW-1:0]  ov_hi;
  logic [CW-1:0]  cnt;
  logic [DW-1:0]  acc_cur;
  logic [IW-1:0]  pos_sh;

  assign shamt    = lrast_pkg::TREE_LEVELS - lvl_r;
  assign size     = NW'(1) << shamt;
  assign off      = node_r & ~(NW'(1) << lvl_r);     // node offset within its level
  assign lo       = IW'(off << shamt);
  assign hi       = IW'({1'b0, lo} + size - NW'(1));
  assign disjoint = (qh_r < lo) || (ql_r > hi);
  assign covered  = (ql_r <= lo) && (hi <= qh_r);
  assign ov_lo    = (ql_r > lo) ? ql_r : lo;
  assign ov_hi    = (qh_r < hi) ? qh_r : hi;
  assign cnt      = CW'(ov_hi) - CW'(ov_lo) + CW'(1);
  assign acc_cur  = acc_r[lvl_r];
  // load path: branch bit for the child below this level
  assign pos_sh   = ql_r >> (lrast_pkg::TREE_LEVELS - LW'(1) - lvl_r);

  // ---------------- node memory writes ----------------
  always_comb begin
    wr = '0;
    wr.addr = node_r;
    case (state_r)
      ST_CLEAR: begin
        wr.sum_we  = 1'b1;
        wr.pend_we = 1'b1;
        wr.addr    = clr_cnt_r;
      end
      ST_EVAL: begin
        if (func_r == lrast_pkg::FUNC_ADD && !disjoint && covered) begin
          // whole segment gets the add; children see it through the pending add
          wr.sum_we  = 1'b1;
          wr.pend_we = 1'b1;
          wr.sum     = rd_sum + (value_r << shamt);
          wr.pend    = rd_pend + value_r;
        end else if (func_r == lrast_pkg::FUNC_LOAD && lvl_r == lrast_pkg::TREE_LEVELS) begin
          // leaf store excludes the adds still pending above it
          wr.sum_we = 1'b1;
          wr.sum    = value_r - acc_cur;
        end
      end
      ST_PWR: begin
        wr.sum_we = 1'b1;
        wr.sum    = keep_r + prod_r;
      end
      ST_LUW: begin
        wr.sum_we = 1'b1;
        wr.sum    = rd_sum + delta_r;
      end
      default: begin
      end
    endcase
  end

  lrast_node_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (node_r),
    .rd_sum  (rd_sum),
    .rd_pend (rd_pend)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      node_r      <= NW'(1);
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_FIN the output register is handled by the state itself
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + NW'(1);
          if (clr_cnt_r == NW'(lrast_pkg::NODE_CNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            func_r   <= in_tuser;
            ql_r     <= in_ql;
            qh_r     <= qh_clip;
            value_r  <= in_value;
            node_r   <= NW'(1);
            lvl_r    <= '0;
            acc_r[0] <= '0;
            total_r  <= '0;
            case (in_tuser)
              lrast_pkg::FUNC_LOAD: begin
                if ({1'b0, in_ql} < len) begin
                  state_r <= ST_RD;
                end
              end
              lrast_pkg::FUNC_ADD: begin
                if (!empty) begin
                  state_r <= ST_RD;
                end
              end
              lrast_pkg::FUNC_SUM: begin
                state_r <= empty ? ST_FIN : ST_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (func_r == lrast_pkg::FUNC_LOAD) begin
            if (lvl_r != lrast_pkg::TREE_LEVELS) begin
              acc_r[lvl_r + LW'(1)] <= acc_cur + rd_pend;
              node_r  <= {node_r[NW-2:0], pos_sh[0]};
              lvl_r   <= lvl_r + LW'(1);
              state_r <= ST_RD;
            end else begin
              // change of the element, carried up to every ancestor sum
              delta_r <= value_r - (rd_sum + acc_cur);
              node_r  <= node_r >> 1;
              lvl_r   <= lvl_r - LW'(1);
              state_r <= ST_LUR;
            end
          end else if (disjoint) begin
            state_r <= ST_ASC;
          end else if (covered) begin
            if (func_r == lrast_pkg::FUNC_SUM) begin
              total_r <= total_r + rd_sum + (acc_cur << shamt);
            end
            state_r <= ST_ASC;
          end else if (func_r == lrast_pkg::FUNC_ADD) begin
            keep_r  <= rd_sum;
            cnt_r   <= cnt;
            state_r <= ST_MUL;
          end else begin
            acc_r[lvl_r + LW'(1)] <= acc_cur + rd_pend;
            node_r  <= node_r << 1;
            lvl_r   <= lvl_r + LW'(1);
            state_r <= ST_RD;
          end
        end
        ST_MUL: begin
          // partial overlap: sum grows by value times the overlapped count
          prod_r  <= value_r * {{(DW-CW){1'b0}}, cnt_r};
          state_r <= ST_PWR;
        end
        ST_PWR: begin
          node_r  <= node_r << 1;
          lvl_r   <= lvl_r + LW'(1);
          state_r <= ST_RD;
        end
        ST_ASC: begin
          if (node_r == NW'(1)) begin
            state_r <= (func_r == lrast_pkg::FUNC_SUM) ? ST_FIN : ST_IDLE;
          end else if (!node_r[0]) begin
            node_r  <= node_r + NW'(1);
            state_r <= ST_RD;
          end else begin
            node_r <= node_r >> 1;
            lvl_r  <= lvl_r - LW'(1);
          end
        end
        ST_LUR: begin
          state_r <= ST_LUW;
        end
        ST_LUW: begin
          if (node_r == NW'(1)) begin
            state_r <= ST_IDLE;
          end else begin
            node_r  <= node_r >> 1;
            lvl_r   <= lvl_r - LW'(1);
            state_r <= ST_LUR;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= total_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
